FILE: src/ilha_pkg.sv
// Shared types, constants and operation codes of the heap allocator.
package ilha_pkg;

    localparam int HEAP_BYTES = 127;
    localparam int HEAP_AW    = $clog2(HEAP_BYTES);

    localparam logic [2:0] OP_ALLOC  = 3'd0;
    localparam logic [2:0] OP_FREE   = 3'd1;
    localparam logic [2:0] OP_RESIZE = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_INFO   = 3'd5;

    typedef struct packed {
        logic [2:0] operation;
        logic [6:0] address;
        logic [6:0] request_size;
        logic [7:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic       status;
        logic [6:0] result_pointer;
        logic [7:0] read_data;
        logic [6:0] block_payload;
        logic       block_allocated;
        logic [7:0] next_pointer;
    } rsp_item_t;

endpackage

FILE: src/implicit_list_heap_allocator.sv
// Top level of the heap allocator: request channel, sequencer and response register.
//
// A byte heap of 127 entries keeps its block headers, (size << 1) | allocated,
// in the heap itself. Each request carries one operation: allocate (best fit
// with split), free (with merge of following free blocks), resize (shrink,
// grow in place, or move by allocate, copy and free), write byte, read byte,
// or block info. Every request produces exactly one response.
//
// Both channels use valid and stall. A request is taken when req_valid is high
// and req_stall is low; req_stall stays high from then until its response has
// been taken, so one request is in the block at a time.
//
// Timing is set by the heap RAM, which the sequencer uses for one access per
// cycle at most, with a registered read: a write answers in the cycle after it
// is taken, a read or block info passes through S_READ or S_INFO and then
// S_FIN, and the next request is taken in the cycle after the response. Free
// time grows with the number of merged blocks, allocate with the number of
// block headers walked, and a resize that moves with the copied bytes.
//
// After reset the sequencer clears all 127 heap bytes, writing one free
// block that spans the whole heap; req_stall is high meanwhile. When the
// receiver stalls, the response holds steady and no new request is taken.
module implicit_list_heap_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ilha_pkg::req_item_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ilha_pkg::rsp_item_t rsp_data
);
    import ilha_pkg::*;

    // Sequencer state codes.
    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_READ      = 5'd2;
    localparam logic [4:0] S_INFO      = 5'd3;
    localparam logic [4:0] S_FREE_RD   = 5'd4;
    localparam logic [4:0] S_FREE_HDR  = 5'd5;
    localparam logic [4:0] S_ABS_RD    = 5'd6;
    localparam logic [4:0] S_ABS_CHK   = 5'd7;
    localparam logic [4:0] S_FREE_WR   = 5'd8;
    localparam logic [4:0] S_RS_HDR    = 5'd9;
    localparam logic [4:0] S_GROW      = 5'd10;
    localparam logic [4:0] S_ALLOC_RD  = 5'd11;
    localparam logic [4:0] S_ALLOC_CHK = 5'd12;
    localparam logic [4:0] S_ALLOC_END = 5'd13;
    localparam logic [4:0] S_SPLIT_HDR = 5'd14;
    localparam logic [4:0] S_SPLIT_REM = 5'd15;
    localparam logic [4:0] S_COPY_RD   = 5'd16;
    localparam logic [4:0] S_COPY_WR   = 5'd17;
    localparam logic [4:0] S_FIN       = 5'd18;

    localparam logic [7:0] HEAP_END  = 8'(HEAP_BYTES);
    localparam logic [7:0] MAX_BLOCK = 8'd127;

    logic [4:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [2:0] op_reg, op_next;
    logic [6:0] addr_reg, addr_next;
    logic [6:0] n_reg, n_next;
    logic [7:0] data_reg, data_next;
    logic [6:0] hdr_reg, hdr_next;
    logic [6:0] s_reg, s_next;
    logic [6:0] sz_reg, sz_next;
    logic       inf_reg, inf_next;
    logic [7:0] i_reg, i_next;
    logic [6:0] best_reg, best_next;
    logic [6:0] bsz_reg, bsz_next;
    logic       found_reg, found_next;
    logic [6:0] base_reg, base_next;
    logic [6:0] size_reg, size_next;
    logic       mv_reg, mv_next;
    logic [6:0] k_reg, k_next;
    logic [6:0] np_reg, np_next;
    rsp_item_t  res_reg, res_next;

    logic               ram_we;
    logic [HEAP_AW-1:0] ram_waddr;
    logic [7:0]         ram_wdata;
    logic [HEAP_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    ilha_ram #(
        .WIDTH (8),
        .DEPTH (HEAP_BYTES)
    ) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Derived values used by several states.
    logic [7:0] n_plus1;
    logic [7:0] nx;
    logic [6:0] h_size;
    logic [7:0] merge_sum;
    logic [7:0] split_addr;
    logic [6:0] split_rem;
    logic [7:0] info_end;
    logic [7:0] copy_src;
    logic [7:0] copy_dst;

    assign n_plus1    = {1'b0, n_reg} + 8'd1;
    assign nx         = {1'b0, hdr_reg} + {1'b0, sz_reg};
    assign h_size     = ram_rdata[7:1];
    assign merge_sum  = {1'b0, sz_reg} + {1'b0, h_size};
    assign split_addr = {1'b0, base_reg} + n_plus1;
    assign split_rem  = size_reg - n_reg - 7'd1;
    assign info_end   = {1'b0, hdr_reg} + {1'b0, h_size};
    assign copy_src   = {1'b0, addr_reg} + {1'b0, k_reg};
    assign copy_dst   = {1'b0, np_reg} + {1'b0, k_reg};

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_FIN);
    assign rsp_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        n_next     = n_reg;
        data_next  = data_reg;
        hdr_next   = hdr_reg;
        s_next     = s_reg;
        sz_next    = sz_reg;
        inf_next   = inf_reg;
        i_next     = i_reg;
        best_next  = best_reg;
        bsz_next   = bsz_reg;
        found_next = found_reg;
        base_next  = base_reg;
        size_next  = size_reg;
        mv_next    = mv_reg;
        k_next     = k_reg;
        np_next    = np_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // The first byte holds one free block covering the heap.
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = (cnt_reg == '0) ? {HEAP_END[6:0], 1'b0} : 8'd0;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'(HEAP_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req_data.operation;
                    addr_next = req_data.address;
                    n_next    = req_data.request_size;
                    data_next = req_data.write_data;
                    hdr_next  = req_data.address - 7'd1;
                    mv_next   = 1'b0;
                    res_next  = '0;
                    unique case (req_data.operation)
                        OP_ALLOC:
                        begin
                            i_next     = '0;
                            found_next = 1'b0;
                            state_next = S_ALLOC_RD;
                        end
                        OP_FREE:
                        begin
                            state_next = (req_data.address != '0) ? S_FREE_RD : S_FIN;
                        end
                        OP_RESIZE:
                        begin
                            ram_raddr = req_data.address - 7'd1;
                            if (req_data.address != '0)
                            begin
                                state_next = S_RS_HDR;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                                state_next      = S_FIN;
                            end
                        end
                        OP_WRITE:
                        begin
                            ram_we     = ({1'b0, req_data.address} < HEAP_END);
                            ram_waddr  = req_data.address;
                            ram_wdata  = req_data.write_data;
                            state_next = S_FIN;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = req_data.address;
                            state_next = ({1'b0, req_data.address} < HEAP_END) ? S_READ
                                                                                : S_FIN;
                        end
                        OP_INFO:
                        begin
                            ram_raddr             = req_data.address - 7'd1;
                            res_next.next_pointer = 8'd128;
                            state_next = (req_data.address != '0) ? S_INFO : S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next.read_data = ram_rdata;
                state_next         = S_FIN;
            end
            S_INFO:
            begin
                res_next.block_allocated = ram_rdata[0];
                res_next.block_payload   = (h_size != '0) ? h_size - 7'd1 : 7'd0;
                if (h_size != '0 && info_end < HEAP_END)
                begin
                    res_next.next_pointer = info_end + 8'd1;
                end
                state_next = S_FIN;
            end
            S_FREE_RD:
            begin
                ram_raddr  = hdr_reg;
                state_next = S_FREE_HDR;
            end
            S_FREE_HDR:
            begin
                sz_next    = h_size;
                inf_next   = 1'b1;
                state_next = S_ABS_RD;
            end
            S_ABS_RD:
            begin
                // Merge loop: look at the block right after the current end.
                ram_raddr = nx[HEAP_AW-1:0];
                if (nx < HEAP_END && (inf_reg || {1'b0, sz_reg} < n_plus1))
                begin
                    state_next = S_ABS_CHK;
                end
                else
                begin
                    state_next = inf_reg ? S_FREE_WR : S_GROW;
                end
            end
            S_ABS_CHK:
            begin
                if (ram_rdata[0] || h_size == '0 || merge_sum > MAX_BLOCK)
                begin
                    state_next = inf_reg ? S_FREE_WR : S_GROW;
                end
                else
                begin
                    sz_next    = merge_sum[6:0];
                    state_next = S_ABS_RD;
                end
            end
            S_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = hdr_reg;
                ram_wdata = {sz_reg, 1'b0};
                if (mv_reg)
                begin
                    res_next.result_pointer = np_reg;
                end
                state_next = S_FIN;
            end
            S_RS_HDR:
            begin
                res_next.result_pointer = addr_reg;
                s_next                  = h_size;
                if ({1'b0, h_size} == n_plus1)
                begin
                    state_next = S_FIN;
                end
                else if ({1'b0, h_size} > n_plus1)
                begin
                    base_next  = hdr_reg;
                    size_next  = h_size;
                    state_next = S_SPLIT_HDR;
                end
                else
                begin
                    sz_next    = h_size;
                    inf_next   = 1'b0;
                    state_next = S_ABS_RD;
                end
            end
            S_GROW:
            begin
                ram_we    = (sz_reg != s_reg);
                ram_waddr = hdr_reg;
                ram_wdata = {sz_reg, 1'b1};
                if ({1'b0, sz_reg} < n_plus1)
                begin
                    // Still too small: move the block.
                    mv_next    = 1'b1;
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = S_ALLOC_RD;
                end
                else if ({1'b0, sz_reg} > n_plus1)
                begin
                    base_next  = hdr_reg;
                    size_next  = sz_reg;
                    state_next = S_SPLIT_HDR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ALLOC_RD:
            begin
                ram_raddr  = i_reg[HEAP_AW-1:0];
                state_next = (i_reg < HEAP_END) ? S_ALLOC_CHK : S_ALLOC_END;
            end
            S_ALLOC_CHK:
            begin
                // Best fit: the first block of the smallest size that is large enough.
                if (h_size == '0)
                begin
                    state_next = S_ALLOC_END;
                end
                else
                begin
                    if (!ram_rdata[0] && h_size > n_reg && (!found_reg || h_size < bsz_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = i_reg[6:0];
                        bsz_next   = h_size;
                    end
                    i_next     = i_reg + {1'b0, h_size};
                    state_next = S_ALLOC_RD;
                end
            end
            S_ALLOC_END:
            begin
                if (!found_reg)
                begin
                    res_next.status         = 1'b1;
                    res_next.result_pointer = (op_reg == OP_ALLOC) ? 7'd0 : addr_reg;
                    state_next              = S_FIN;
                end
                else
                begin
                    base_next  = best_reg;
                    size_next  = bsz_reg;
                    state_next = S_SPLIT_HDR;
                end
            end
            S_SPLIT_HDR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = base_reg;
                ram_wdata  = {n_plus1[6:0], 1'b1};
                state_next = S_SPLIT_REM;
            end
            S_SPLIT_REM:
            begin
                ram_we    = ({1'b0, size_reg} > n_plus1) && (split_addr < HEAP_END);
                ram_waddr = split_addr[HEAP_AW-1:0];
                ram_wdata = {split_rem, 1'b0};
                if (op_reg == OP_ALLOC)
                begin
                    res_next.result_pointer = base_reg + 7'd1;
                    state_next              = S_FIN;
                end
                else if (mv_reg)
                begin
                    np_next    = base_reg + 7'd1;
                    k_next     = '0;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_COPY_RD:
            begin
                ram_raddr = copy_src[HEAP_AW-1:0];
                if (({1'b0, k_reg} + 8'd1) < {1'b0, s_reg})
                begin
                    state_next = S_COPY_WR;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_COPY_WR:
            begin
                ram_we     = (copy_dst < HEAP_END);
                ram_waddr  = copy_dst[HEAP_AW-1:0];
                ram_wdata  = (copy_src < HEAP_END) ? ram_rdata : 8'd0;
                k_next     = k_reg + 7'd1;
                state_next = S_COPY_RD;
            end
            S_FIN:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        n_reg     <= n_next;
        data_reg  <= data_next;
        hdr_reg   <= hdr_next;
        s_reg     <= s_next;
        sz_reg    <= sz_next;
        inf_reg   <= inf_next;
        i_reg     <= i_next;
        best_reg  <= best_next;
        bsz_reg   <= bsz_next;
        found_reg <= found_next;
        base_reg  <= base_next;
        size_reg  <= size_next;
        k_reg     <= k_next;
        np_reg    <= np_next;
        res_reg   <= res_next;
    end

endmodule

FILE: src/ilha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ilha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sim/tb_implicit_list_heap_allocator.sv
// Testbench for the implicit-list heap allocator: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_implicit_list_heap_allocator;

    import ilha_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 800;
    localparam int MAX_BLK        = 127;
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req_data;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp_data;

    implicit_list_heap_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Shadow copy of the heap, kept in step with every accepted request.
    logic [7:0] shadow_heap [HEAP_BYTES];

    // Responses still owed by the block, oldest first.
    rsp_item_t pending_rsp [$];

    int  fail_count;
    int  idle_cycles;
    bit  quiet_mode;      // When set, neither side inserts random idles.

    // One row of the directed table. When check_fixed is set, the typed-in
    // response must also agree with what the shadow model predicts.
    typedef struct {
        req_item_t req;
        bit        check_fixed;
        rsp_item_t fixed_rsp;
    } directed_row_t;

    function automatic logic [7:0] heap_rd(int a);
        return (a < HEAP_BYTES) ? shadow_heap[a] : 8'd0;
    endfunction

    function automatic void heap_wr(int a, int v);
        if (a < HEAP_BYTES)
            shadow_heap[a] = v[7:0];
    endfunction

    // Grow the block at hdr over free neighbors until its payload reaches want.
    function automatic int grow_over_free(int hdr, int sz, int want);
        int nx;
        int h;
        int ns;
        nx = hdr + sz;
        while (nx < HEAP_BYTES && sz - 1 < want)
        begin
            h  = shadow_heap[nx];
            ns = h >> 1;
            if ((h & 1) != 0 || ns == 0 || sz + ns > MAX_BLK)
                break;
            sz += ns;
            nx = hdr + sz;
        end
        return sz;
    endfunction

    function automatic void release_block(int hdr);
        int sz;
        sz = grow_over_free(hdr, shadow_heap[hdr] >> 1, 1000);
        shadow_heap[hdr] = 8'((sz << 1) & 8'hFE);
    endfunction

    function automatic void carve_block(int hdr, int sz, int n);
        shadow_heap[hdr] = 8'((((n + 1) << 1) | 1) & 8'hFF);
        heap_wr(hdr + n + 1, (sz - n - 1) << 1);
    endfunction

    // Best-fit search: the first smallest free block strictly larger than n.
    function automatic bit best_fit_alloc(int n, output int ptr);
        int  i;
        int  h;
        int  sz;
        int  best;
        int  best_sz;
        bit  found;
        i = 0;
        best = 0;
        best_sz = 0;
        found = 1'b0;
        ptr = 0;
        while (i < HEAP_BYTES)
        begin
            h  = shadow_heap[i];
            sz = h >> 1;
            if (sz == 0)
                break;
            if ((h & 1) == 0 && sz > n && (!found || sz < best_sz))
            begin
                found   = 1'b1;
                best    = i;
                best_sz = sz;
            end
            i += sz;
        end
        if (!found)
            return 1'b0;
        if (n + 1 < best_sz)
            heap_wr(best + n + 1, (best_sz - n - 1) << 1);
        shadow_heap[best] = 8'((((n + 1) << 1) | 1) & 8'hFF);
        ptr = best + 1;
        return 1'b1;
    endfunction

    // Apply one request to the shadow heap and return the response it causes.
    function automatic rsp_item_t predict_heap_op(req_item_t r);
        rsp_item_t o;
        int  addr;
        int  n;
        bit  hdr_ok;
        int  hdr;
        int  s;
        int  ps;
        int  s2;
        int  np;
        int  h;
        int  sz;
        o = '0;
        addr = r.address;
        n = r.request_size;
        hdr_ok = addr >= 1 && addr - 1 < HEAP_BYTES;
        hdr = hdr_ok ? addr - 1 : 0;
        unique case (r.operation)
            OP_ALLOC:
            begin
                if (best_fit_alloc(n, np))
                    o.result_pointer = np[6:0];
                else
                    o.status = 1'b1;
            end
            OP_FREE:
            begin
                if (hdr_ok)
                    release_block(hdr);
            end
            OP_RESIZE:
            begin
                if (!hdr_ok)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    s  = shadow_heap[hdr] >> 1;
                    ps = s - 1;
                    o.result_pointer = addr[6:0];
                    if (ps > n)
                    begin
                        carve_block(hdr, s, n);
                    end
                    else if (ps < n)
                    begin
                        s2 = grow_over_free(hdr, s, n);
                        if (s2 != s)
                            shadow_heap[hdr] = 8'(((s2 << 1) | 1) & 8'hFF);
                        if (s2 - 1 < n)
                        begin
                            if (best_fit_alloc(n, np))
                            begin
                                // Only the old payload moves across.
                                for (int k = 0; k + 1 < s; k++)
                                    heap_wr(np + k, heap_rd(addr + k));
                                release_block(hdr);
                                o.result_pointer = np[6:0];
                            end
                            else
                            begin
                                o.status = 1'b1;
                            end
                        end
                        else if (s2 - 1 > n)
                        begin
                            carve_block(hdr, s2, n);
                        end
                    end
                end
            end
            OP_WRITE: heap_wr(addr, r.write_data);
            OP_READ:  o.read_data = heap_rd(addr);
            OP_INFO:
            begin
                o.next_pointer = 8'd128;
                if (hdr_ok)
                begin
                    h  = shadow_heap[hdr];
                    sz = h >> 1;
                    o.block_allocated = h[0];
                    o.block_payload   = 7'((sz > 0) ? sz - 1 : 0);
                    if (sz != 0 && hdr + sz < HEAP_BYTES)
                        o.next_pointer = 8'(hdr + sz + 1);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Known live blocks, so random traffic mostly aims at real pointers.
    int live_ptrs [$];

    function automatic req_item_t make_req(logic [2:0] op, int a, int n, int d);
        req_item_t r;
        r.operation    = op;
        r.address      = a[6:0];
        r.request_size = n[6:0];
        r.write_data   = d[7:0];
        return r;
    endfunction

    // Random request: mostly well-formed heap traffic, some noise.
    function automatic req_item_t random_req();
        int pick;
        int ptr;
        int sz;
        pick = $urandom_range(0, 99);
        // Sizes are mostly small so that many blocks coexist.
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                          : $urandom_range(0, 20);
        ptr = (live_ptrs.size() > 0)
            ? live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]
            : $urandom_range(0, 127);
        if (pick < 25)
            return make_req(OP_ALLOC, $urandom_range(0, 127), sz, $urandom_range(0, 255));
        else if (pick < 40)
            return make_req(OP_FREE, ptr, $urandom_range(0, 127), $urandom_range(0, 255));
        else if (pick < 52)
            return make_req(OP_RESIZE, ptr, sz, $urandom_range(0, 255));
        else if (pick < 67)
            return make_req(OP_WRITE, ptr + $urandom_range(0, 8), $urandom_range(0, 127),
                            $urandom_range(0, 255));
        else if (pick < 80)
            return make_req(OP_READ, ptr + $urandom_range(0, 8), $urandom_range(0, 127),
                            $urandom_range(0, 255));
        else if (pick < 92)
            return make_req(OP_INFO, ptr, $urandom_range(0, 127), $urandom_range(0, 255));
        // Noise: any field value, unused operation codes included.
        return make_req(3'($urandom_range(0, 7)), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 255));
    endfunction

    // Keep the pointer list in line with what a request did to the heap.
    function automatic void track_ptrs(req_item_t r, rsp_item_t o);
        if (r.operation == OP_ALLOC && !o.status)
            live_ptrs.push_back(o.result_pointer);
        else if (r.operation == OP_RESIZE && !o.status && o.result_pointer != r.address)
            live_ptrs.push_back(o.result_pointer);
        else if (r.operation == OP_FREE && live_ptrs.size() > 8)
            live_ptrs.delete($urandom_range(0, live_ptrs.size() - 1));
    endfunction

    // Present one request and hold it until the block takes it. Valid stays
    // high after acceptance until the next call drives it again, so it is
    // assigned once per time step.
    task automatic send_request(req_item_t r, bit check_fixed, rsp_item_t fixed_rsp);
        rsp_item_t exp_rsp;
        if (!quiet_mode)
        begin
            while ($urandom_range(0, 99) < 8)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // Accepted at this edge; predict in request order.
        exp_rsp = predict_heap_op(r);
        if (check_fixed && exp_rsp != fixed_rsp)
        begin
            $error("directed row: expected %h, model predicts %h", fixed_rsp, exp_rsp);
            fail_count++;
        end
        pending_rsp.push_back(exp_rsp);
        track_ptrs(r, exp_rsp);
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Response side: random stall, and a field-by-field compare on acceptance.
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response with nothing outstanding: %h", rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        fail_count++;
                    end
                    if (rsp_data.result_pointer !== want.result_pointer)
                    begin
                        $error("result_pointer: expected %0d, got %0d",
                               want.result_pointer, rsp_data.result_pointer);
                        fail_count++;
                    end
                    if (rsp_data.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0d, got %0d",
                               want.read_data, rsp_data.read_data);
                        fail_count++;
                    end
                    if (rsp_data.block_payload !== want.block_payload)
                    begin
                        $error("block_payload: expected %0d, got %0d",
                               want.block_payload, rsp_data.block_payload);
                        fail_count++;
                    end
                    if (rsp_data.block_allocated !== want.block_allocated)
                    begin
                        $error("block_allocated: expected %0d, got %0d",
                               want.block_allocated, rsp_data.block_allocated);
                        fail_count++;
                    end
                    if (rsp_data.next_pointer !== want.next_pointer)
                    begin
                        $error("next_pointer: expected %0d, got %0d",
                               want.next_pointer, rsp_data.next_pointer);
                        fail_count++;
                    end
                end
            end
        end
        rsp_stall <= (!rst_n || quiet_mode) ? 1'b0 : ($urandom_range(0, 99) < 8);
    end

    // Watchdog: any cycle with a handshake on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic rsp_item_t rsp_of(int st, int rp, int rd, int bp, int ba, int nx);
        rsp_item_t o;
        o.status          = st[0];
        o.result_pointer  = rp[6:0];
        o.read_data       = rd[7:0];
        o.block_payload   = bp[6:0];
        o.block_allocated = ba[0];
        o.next_pointer    = nx[7:0];
        return o;
    endfunction

    directed_row_t directed_rows [$];

    task automatic add_row(req_item_t r, int chk, rsp_item_t o);
        directed_row_t row;
        row.req = r;
        row.check_fixed = (chk != 0);
        row.fixed_rsp = o;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        fail_count = 0;
        quiet_mode = 1'b0;
        for (int i = 0; i < HEAP_BYTES; i++)
            shadow_heap[i] = 8'd0;
        shadow_heap[0] = 8'((HEAP_BYTES << 1) & 8'hFE);

        // Directed table. Rows that can be read straight off the heap layout
        // carry their response; the rest rely on the shadow model.
        add_row(make_req(OP_INFO, 1, 0, 0), 1, rsp_of(0, 0, 0, 126, 0, 128));
        add_row(make_req(OP_INFO, 0, 0, 0), 1, rsp_of(0, 0, 0, 0, 0, 128));
        add_row(make_req(OP_ALLOC, 0, 127, 0), 1, rsp_of(1, 0, 0, 0, 0, 0));
        add_row(make_req(OP_ALLOC, 0, 126, 0), 1, rsp_of(0, 1, 0, 0, 0, 0));
        add_row(make_req(OP_INFO, 1, 0, 0), 1, rsp_of(0, 0, 0, 126, 1, 128));
        add_row(make_req(OP_ALLOC, 0, 0, 0), 1, rsp_of(1, 0, 0, 0, 0, 0));
        add_row(make_req(OP_FREE, 1, 0, 0), 0, '0);
        add_row(make_req(OP_ALLOC, 0, 10, 0), 1, rsp_of(0, 1, 0, 0, 0, 0));
        add_row(make_req(OP_ALLOC, 0, 0, 0), 1, rsp_of(0, 12, 0, 0, 0, 0));
        add_row(make_req(OP_ALLOC, 0, 20, 0), 0, '0);
        add_row(make_req(OP_WRITE, 2, 0, 255), 0, '0);
        add_row(make_req(OP_WRITE, 127, 0, 170), 0, '0);
        add_row(make_req(OP_READ, 127, 0, 0), 1, rsp_of(0, 0, 0, 0, 0, 0));
        add_row(make_req(OP_READ, 2, 0, 0), 0, '0);
        add_row(make_req(OP_RESIZE, 1, 10, 0), 0, '0);      // same size
        add_row(make_req(OP_RESIZE, 1, 4, 0), 0, '0);       // shrink with split
        add_row(make_req(OP_RESIZE, 1, 40, 0), 0, '0);      // grow or move
        add_row(make_req(OP_RESIZE, 0, 5, 0), 1, rsp_of(1, 0, 0, 0, 0, 0));
        add_row(make_req(OP_RESIZE, 13, 126, 0), 0, '0);    // move that fails
        add_row(make_req(OP_FREE, 0, 0, 0), 0, '0);         // bad pointer
        add_row(make_req(OP_FREE, 13, 0, 0), 0, '0);
        add_row(make_req(OP_INFO, 127, 0, 0), 0, '0);
        add_row(make_req(OP_UNUSED6, 127, 127, 255), 1, rsp_of(0, 0, 0, 0, 0, 0));
        add_row(make_req(OP_UNUSED7, 85, 85, 85), 1, rsp_of(0, 0, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].check_fixed,
                         directed_rows[i].fixed_rsp);

        // The sender holds off here until the block has answered everything.
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // A long stretch in the middle runs with no idling on either side.
            quiet_mode = (i >= 300 && i < 420);
            if (i == 600)
                wait_drained();
            send_request(random_req(), 1'b0, '0);
        end
        quiet_mode = 1'b0;

        wait_drained();
        repeat (300) @(posedge clk);

        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
src/ilha_pkg.sv
src/ilha_ram.sv
src/implicit_list_heap_allocator.sv
sim/tb_implicit_list_heap_allocator.sv
